>>> design/hsv2rgb_pkg.sv
// Shared constants for the HSV to RGB pixel pipeline.
package hsv2rgb_pkg;

   // Hue is in 1/16 degree: one 60-degree sector is 960 units
   localparam int unsigned HUE_W = 13;
   localparam logic [HUE_W-1:0] SECTOR_UNITS = 13'd960;
   localparam logic [HUE_W-1:0] HUE_LIMIT    = 13'd5760;

   // Color channel width and full scale
   localparam int unsigned CH_W = 8;
   localparam logic [CH_W-1:0] FULL_SCALE = 8'd255;

   // Secondary term: ceil(s*v*dist / (255*960))
   localparam int unsigned PROD_W = 26;   // s*v*dist < 2^26
   localparam int unsigned REM_W  = 19;   // remainder below twice the divisor
   localparam logic [PROD_W-1:0] SEC_DIV = 26'd244800;

   // floor(2^34 / 244800): the estimate is exact or one low for all products
   localparam int unsigned RECIP_SHIFT = 34;
   localparam int unsigned RECIP_W     = 17;
   localparam logic [RECIP_W-1:0] SEC_RECIP = 17'd70179;

   // Sector codes, one per 60 degrees
   localparam int unsigned SEC_W = 3;
   localparam logic [SEC_W-1:0] SEC_RED_YELLOW    = 3'd0;
   localparam logic [SEC_W-1:0] SEC_YELLOW_GREEN  = 3'd1;
   localparam logic [SEC_W-1:0] SEC_GREEN_CYAN    = 3'd2;
   localparam logic [SEC_W-1:0] SEC_CYAN_BLUE     = 3'd3;
   localparam logic [SEC_W-1:0] SEC_BLUE_MAGENTA  = 3'd4;
   localparam logic [SEC_W-1:0] SEC_MAGENTA_RED   = 3'd5;

endpackage

>>> design/hsv_to_rgb_pixel.sv
// HSV to RGB pixel converter: five-stage pipeline, one pixel per cycle.
//
//  channel   signals                                   handshake
//  -------   ---------------------------------------   -----------------------------
//  request   req_pixel_index req_hue                   start high, busy low
//            req_saturation req_brightness
//  response  rsp_out_index rsp_red rsp_green rsp_blue   rsp_valid strobe, one cycle
//
// Throughput is one transaction per cycle; busy is always low.
// The stages hold the multiply chain s*v, s*v*dist, the reciprocal multiply and its correction.
// Synchronous reset clears the stage valid bits; data registers are not reset.
// The receiver cannot stall, so the pipeline never holds and never drops a transaction.
module hsv_to_rgb_pixel #(
   parameter int unsigned PIXEL_COUNT = 1024
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     start,
   output logic                                     busy,
   input  logic [((PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1)-1:0] req_pixel_index,
   input  logic [hsv2rgb_pkg::HUE_W-1:0]            req_hue,
   input  logic [hsv2rgb_pkg::CH_W-1:0]             req_saturation,
   input  logic [hsv2rgb_pkg::CH_W-1:0]             req_brightness,
   output logic                                     rsp_valid,
   output logic [((PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1)-1:0] rsp_out_index,
   output logic [hsv2rgb_pkg::CH_W-1:0]             rsp_red,
   output logic [hsv2rgb_pkg::CH_W-1:0]             rsp_green,
   output logic [hsv2rgb_pkg::CH_W-1:0]             rsp_blue
);
   import hsv2rgb_pkg::*;

   localparam int unsigned IDX_W  = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
   localparam int unsigned STAGES = 5;

   localparam logic [HUE_W-1:0] TWO_SECTORS  = 13'd1920;
   localparam logic [HUE_W-1:0] FOUR_SECTORS = 13'd3840;

   // ---------------- valid chain ----------------
   logic              accept;
   logic [STAGES-1:0] vld_ff, vld_in;

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign vld_in = {vld_ff[STAGES-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // ---------------- stage 1: products, sector, distance ----------------
   logic [2*CH_W-1:0] sv_ff, sv_in;
   logic [2*CH_W-1:0] zn_ff, zn_in;
   logic [9:0]        dist1_ff, dist1_in;
   logic [SEC_W-1:0]  sec1_ff, sec1_in;
   logic              cube1_ff, cube1_in;
   logic [CH_W-1:0]   v1_ff;
   logic [IDX_W-1:0]  idx1_ff;
   logic [HUE_W-1:0]  hue_mod;
   logic [HUE_W-1:0]  hue_dist;

   always_comb begin
      sv_in    = req_saturation * req_brightness;
      zn_in    = req_brightness * (FULL_SCALE - req_saturation);
      cube1_in = (req_hue < HUE_LIMIT);

      // sector by threshold compares
      if (req_hue < SECTOR_UNITS)                 sec1_in = SEC_RED_YELLOW;
      else if (req_hue < 13'd1920)                sec1_in = SEC_YELLOW_GREEN;
      else if (req_hue < 13'd2880)                sec1_in = SEC_GREEN_CYAN;
      else if (req_hue < 13'd3840)                sec1_in = SEC_CYAN_BLUE;
      else if (req_hue < 13'd4800)                sec1_in = SEC_BLUE_MAGENTA;
      else                                        sec1_in = SEC_MAGENTA_RED;

      // hue mod 120 degrees, then distance from the 60-degree point
      if (req_hue >= FOUR_SECTORS)     hue_mod = req_hue - FOUR_SECTORS;
      else if (req_hue >= TWO_SECTORS) hue_mod = req_hue - TWO_SECTORS;
      else                             hue_mod = req_hue;

      if (hue_mod >= SECTOR_UNITS) hue_dist = hue_mod - SECTOR_UNITS;
      else                         hue_dist = SECTOR_UNITS - hue_mod;
      dist1_in = hue_dist[9:0];
   end

   always_ff @(posedge clock) begin
      sv_ff    <= sv_in;
      zn_ff    <= zn_in;
      dist1_ff <= dist1_in;
      sec1_ff  <= sec1_in;
      cube1_ff <= cube1_in;
      v1_ff    <= req_brightness;
      idx1_ff  <= req_pixel_index;
   end

   // ---------------- stage 2: s*v*dist, zero channel ----------------
   logic [PROD_W-1:0] p2_ff, p2_in;
   logic [CH_W-1:0]   z2_ff, z2_in;
   logic [2*CH_W:0]   zsum;
   logic [SEC_W-1:0]  sec2_ff;
   logic              cube2_ff;
   logic [CH_W-1:0]   v2_ff;
   logic [IDX_W-1:0]  idx2_ff;

   always_comb begin
      p2_in = PROD_W'(sv_ff * dist1_ff);
      // exact floor(n/255) for n up to 255*255
      zsum  = {1'b0, zn_ff} + {9'd0, zn_ff[2*CH_W-1:CH_W]} + 17'd1;
      z2_in = zsum[2*CH_W-1:CH_W];
   end

   always_ff @(posedge clock) begin
      p2_ff    <= p2_in;
      z2_ff    <= z2_in;
      sec2_ff  <= sec1_ff;
      cube2_ff <= cube1_ff;
      v2_ff    <= v1_ff;
      idx2_ff  <= idx1_ff;
   end

   // ---------------- stage 3: quotient estimate by reciprocal ----------------
   logic [PROD_W+RECIP_W-1:0] qprod;
   logic [CH_W-1:0]   qe3_ff, qe3_in;
   logic [PROD_W-1:0] p3_ff;
   logic [CH_W-1:0]   z3_ff;
   logic [SEC_W-1:0]  sec3_ff;
   logic              cube3_ff;
   logic [CH_W-1:0]   v3_ff;
   logic [IDX_W-1:0]  idx3_ff;

   always_comb begin
      qprod  = p2_ff * SEC_RECIP;
      qe3_in = qprod[RECIP_SHIFT+CH_W-1:RECIP_SHIFT];
   end

   always_ff @(posedge clock) begin
      qe3_ff   <= qe3_in;
      p3_ff    <= p2_ff;
      z3_ff    <= z2_ff;
      sec3_ff  <= sec2_ff;
      cube3_ff <= cube2_ff;
      v3_ff    <= v2_ff;
      idx3_ff  <= idx2_ff;
   end

   // ---------------- stage 4: remainder ----------------
   logic [PROD_W-1:0] rem_full;
   logic [REM_W-1:0]  rem4_ff, rem4_in;
   logic [CH_W-1:0]   qe4_ff;
   logic [CH_W-1:0]   z4_ff;
   logic [SEC_W-1:0]  sec4_ff;
   logic              cube4_ff;
   logic [CH_W-1:0]   v4_ff;
   logic [IDX_W-1:0]  idx4_ff;

   always_comb begin
      rem_full = p3_ff - PROD_W'(qe3_ff * SEC_DIV);
      rem4_in  = rem_full[REM_W-1:0];
   end

   always_ff @(posedge clock) begin
      rem4_ff  <= rem4_in;
      qe4_ff   <= qe3_ff;
      z4_ff    <= z3_ff;
      sec4_ff  <= sec3_ff;
      cube4_ff <= cube3_ff;
      v4_ff    <= v3_ff;
      idx4_ff  <= idx3_ff;
   end

   // ---------------- stage 5: ceiling, secondary, channel select ----------------
   logic [CH_W:0]   ceil_q;
   logic [CH_W-1:0] x5;
   logic [CH_W-1:0] red_ff, red_in;
   logic [CH_W-1:0] green_ff, green_in;
   logic [CH_W-1:0] blue_ff, blue_in;
   logic [IDX_W-1:0] idx5_ff;

   always_comb begin
      ceil_q = {1'b0, qe4_ff}
             + {{CH_W{1'b0}}, (rem4_ff != '0)}
             + {{CH_W{1'b0}}, (rem4_ff > SEC_DIV[REM_W-1:0])};
      x5     = v4_ff - ceil_q[CH_W-1:0];

      red_in   = z4_ff;
      green_in = z4_ff;
      blue_in  = z4_ff;
      if (cube4_ff) begin
         case (sec4_ff)
            SEC_RED_YELLOW: begin
               red_in   = v4_ff;
               green_in = x5;
            end
            SEC_YELLOW_GREEN: begin
               red_in   = x5;
               green_in = v4_ff;
            end
            SEC_GREEN_CYAN: begin
               green_in = v4_ff;
               blue_in  = x5;
            end
            SEC_CYAN_BLUE: begin
               green_in = x5;
               blue_in  = v4_ff;
            end
            SEC_BLUE_MAGENTA: begin
               red_in   = x5;
               blue_in  = v4_ff;
            end
            default: begin
               red_in   = v4_ff;
               blue_in  = x5;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      red_ff   <= red_in;
      green_ff <= green_in;
      blue_ff  <= blue_in;
      idx5_ff  <= idx4_ff;
   end

   assign rsp_valid     = vld_ff[STAGES-1];
   assign rsp_out_index = idx5_ff;
   assign rsp_red       = red_ff;
   assign rsp_green     = green_ff;
   assign rsp_blue      = blue_ff;

   // ---------------- assertions ----------------
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##5 rsp_valid)
      else $error("accepted transaction did not produce a response after five cycles");

   a_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_out_index == $past(req_pixel_index, 5)))
      else $error("response index does not match the request index");

   a_gray: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && ($past(req_hue, 5) >= HUE_LIMIT))
      |-> ((rsp_red == rsp_green) && (rsp_green == rsp_blue)))
      else $error("out-of-range hue did not give equal channels");

   a_chroma: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && ($past(req_hue, 5) < HUE_LIMIT))
      |-> ((rsp_red == $past(req_brightness, 5)) || (rsp_green == $past(req_brightness, 5))
           || (rsp_blue == $past(req_brightness, 5))))
      else $error("no channel carries the value term");

endmodule

>>> dv/hsv_to_rgb_pixel_check.sv
// Checker for the HSV to RGB pixel converter: predicts each response and compares it.
module hsv_to_rgb_pixel_check #(
   parameter int unsigned IDX_W = 10
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic                           busy,
   input  logic [IDX_W-1:0]               req_pixel_index,
   input  logic [hsv2rgb_pkg::HUE_W-1:0]  req_hue,
   input  logic [hsv2rgb_pkg::CH_W-1:0]   req_saturation,
   input  logic [hsv2rgb_pkg::CH_W-1:0]   req_brightness,
   input  logic                           rsp_valid,
   input  logic [IDX_W-1:0]               rsp_out_index,
   input  logic [hsv2rgb_pkg::CH_W-1:0]   rsp_red,
   input  logic [hsv2rgb_pkg::CH_W-1:0]   rsp_green,
   input  logic [hsv2rgb_pkg::CH_W-1:0]   rsp_blue,
   output int unsigned                    mismatches,
   output int unsigned                    outstanding,
   output int unsigned                    responses
);
   import hsv2rgb_pkg::*;

   typedef struct packed {
      logic [IDX_W-1:0] index;
      logic [CH_W-1:0]  red;
      logic [CH_W-1:0]  green;
      logic [CH_W-1:0]  blue;
   } rgb_pixel_type;

   // Colors still in flight through the pipeline, oldest first
   rgb_pixel_type rgb_in_flight_q[$];

   // Exact rational HSV to RGB, each channel floored
   function automatic rgb_pixel_type hsv_to_rgb(input logic [IDX_W-1:0] idx,
                                                input logic [HUE_W-1:0] hue,
                                                input logic [CH_W-1:0] sat,
                                                input logic [CH_W-1:0] val);
      int unsigned hue_u, sat_u, val_u, units, divisor;
      int unsigned floor_level, fold, span, mid_level;
      logic [SEC_W-1:0] sector;
      rgb_pixel_type pix;
      hue_u   = hue;
      sat_u   = sat;
      val_u   = val;
      units   = SECTOR_UNITS;
      divisor = SEC_DIV;
      // Channel that gets no chroma: v*(1-s)
      floor_level = (val_u * (FULL_SCALE - sat_u)) / FULL_SCALE;
      pix.index = idx;
      pix.red   = floor_level[CH_W-1:0];
      pix.green = floor_level[CH_W-1:0];
      pix.blue  = floor_level[CH_W-1:0];
      if (hue_u < HUE_LIMIT) begin
         sector = SEC_W'(hue_u / units);
         fold   = hue_u % (2 * units);
         span   = (fold >= units) ? (fold - units) : (units - fold);
         // Secondary channel: v less the rounded-up chroma share away from the peak
         mid_level = val_u - (sat_u * val_u * span + divisor - 1) / divisor;
         case (sector)
            SEC_RED_YELLOW: begin
               pix.red = val; pix.green = mid_level[CH_W-1:0];
            end
            SEC_YELLOW_GREEN: begin
               pix.red = mid_level[CH_W-1:0]; pix.green = val;
            end
            SEC_GREEN_CYAN: begin
               pix.green = val; pix.blue = mid_level[CH_W-1:0];
            end
            SEC_CYAN_BLUE: begin
               pix.green = mid_level[CH_W-1:0]; pix.blue = val;
            end
            SEC_BLUE_MAGENTA: begin
               pix.red = mid_level[CH_W-1:0]; pix.blue = val;
            end
            default: begin
               pix.red = val; pix.blue = mid_level[CH_W-1:0];
            end
         endcase
      end
      return pix;
   endfunction

   // Retire responses first, then log newly accepted transactions
   always @(posedge clock) begin
      rgb_pixel_type want;
      if (!reset) begin
         if (rsp_valid === 1'b1) begin
            responses++;
            if (rgb_in_flight_q.size() == 0) begin
               $error("response with no transaction in flight: index %0d", rsp_out_index);
               mismatches++;
            end else begin
               want = rgb_in_flight_q.pop_front();
               if (rsp_out_index !== want.index) begin
                  $error("out_index: expected %0d, actual %0d", want.index, rsp_out_index);
                  mismatches++;
               end
               if (rsp_red !== want.red) begin
                  $error("red: expected %0d, actual %0d", want.red, rsp_red);
                  mismatches++;
               end
               if (rsp_green !== want.green) begin
                  $error("green: expected %0d, actual %0d", want.green, rsp_green);
                  mismatches++;
               end
               if (rsp_blue !== want.blue) begin
                  $error("blue: expected %0d, actual %0d", want.blue, rsp_blue);
                  mismatches++;
               end
            end
         end
         if (start === 1'b1 && busy === 1'b0)
            rgb_in_flight_q.push_back(hsv_to_rgb(req_pixel_index, req_hue,
                                                 req_saturation, req_brightness));
      end
      outstanding = rgb_in_flight_q.size();
   end

endmodule

>>> dv/hsv_to_rgb_pixel_test.sv
// Testbench top for the HSV to RGB pixel converter: stimulus, watchdog and verdict.
module hsv_to_rgb_pixel_test;
   import hsv2rgb_pkg::*;

   localparam int unsigned PIXELS     = 1024;
   localparam int unsigned IDX_W      = 10;
   localparam int unsigned PER_PHASE  = 600;
   localparam int unsigned STALL_MAX  = 4000;
   localparam int unsigned TAIL_WAIT  = 10;

   logic              clock = 1'b0;
   logic              reset;
   logic              start;
   logic              busy;
   logic [IDX_W-1:0]  req_pixel_index;
   logic [HUE_W-1:0]  req_hue;
   logic [CH_W-1:0]   req_saturation;
   logic [CH_W-1:0]   req_brightness;
   logic              rsp_valid;
   logic [IDX_W-1:0]  rsp_out_index;
   logic [CH_W-1:0]   rsp_red;
   logic [CH_W-1:0]   rsp_green;
   logic [CH_W-1:0]   rsp_blue;

   int unsigned mismatches, outstanding, responses;
   int unsigned pixels_sent = 0;
   int unsigned idle_pct = 0;
   int unsigned quiet_cycles = 0;

   hsv_to_rgb_pixel #(.PIXEL_COUNT(PIXELS)) dut (
      .clock, .reset, .start, .busy,
      .req_pixel_index, .req_hue, .req_saturation, .req_brightness,
      .rsp_valid, .rsp_out_index, .rsp_red, .rsp_green, .rsp_blue
   );

   hsv_to_rgb_pixel_check #(.IDX_W(IDX_W)) pixel_check (
      .clock, .reset, .start, .busy,
      .req_pixel_index, .req_hue, .req_saturation, .req_brightness,
      .rsp_valid, .rsp_out_index, .rsp_red, .rsp_green, .rsp_blue,
      .mismatches, .outstanding, .responses
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Watchdog: cycles with neither a request nor a response transaction
   always @(posedge clock) begin
      if ((start === 1'b1 && busy === 1'b0) || rsp_valid === 1'b1)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_MAX) begin
         $display("** hsv_to_rgb_pixel: FAILED **");
         $finish;
      end
   end

   // One request transaction; random idle cycles with junk on the data ports first
   task automatic send_pixel(input logic [IDX_W-1:0] idx, input logic [HUE_W-1:0] hue,
                             input logic [CH_W-1:0] sat, input logic [CH_W-1:0] val);
      while ($urandom_range(99) < idle_pct) begin
         start           <= 1'b0;
         req_pixel_index <= IDX_W'($urandom);
         req_hue         <= HUE_W'($urandom);
         req_saturation  <= CH_W'($urandom);
         req_brightness  <= CH_W'($urandom);
         @(posedge clock);
      end
      start           <= 1'b1;
      req_pixel_index <= idx;
      req_hue         <= hue;
      req_saturation  <= sat;
      req_brightness  <= val;
      @(negedge clock);
      while (busy !== 1'b0) begin
         @(posedge clock);
         @(negedge clock);
      end
      @(posedge clock);
      pixels_sent++;
   endtask

   // Hold off until every transaction in flight has come back
   task automatic drain_pipeline();
      start <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
      @(posedge clock);
   endtask

   // Random pixel, weighted toward valid hues and sector boundaries
   task automatic send_random_pixel();
      logic [HUE_W-1:0] hue;
      logic [CH_W-1:0]  sat, val;
      int unsigned      pick;
      pick = $urandom_range(99);
      if (pick < 70)
         hue = HUE_W'($urandom_range(HUE_LIMIT - 1, 0));
      else if (pick < 85)
         hue = HUE_W'(SECTOR_UNITS * $urandom_range(6, 1) - 1 + $urandom_range(2, 0));
      else
         hue = HUE_W'($urandom);
      sat = ($urandom_range(9) == 0) ? ($urandom_range(1) ? FULL_SCALE : '0) : CH_W'($urandom);
      val = ($urandom_range(9) == 0) ? ($urandom_range(1) ? FULL_SCALE : '0) : CH_W'($urandom);
      send_pixel(IDX_W'($urandom), hue, sat, val);
   endtask

   initial begin
      reset           <= 1'b1;
      start           <= 1'b0;
      req_pixel_index <= '0;
      req_hue         <= '0;
      req_saturation  <= '0;
      req_brightness  <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed: sector edges, full-circle hues, saturation and value extremes
      idle_pct = 0;
      send_pixel(10'd0,    13'd0,    8'd255, 8'd255);
      send_pixel(10'd1023, 13'd959,  8'd255, 8'd255);
      send_pixel(10'd1,    13'd960,  8'd255, 8'd255);
      send_pixel(10'd2,    13'd1919, 8'd255, 8'd255);
      send_pixel(10'd3,    13'd1920, 8'd255, 8'd255);
      send_pixel(10'd4,    13'd2880, 8'd255, 8'd255);
      send_pixel(10'd5,    13'd3840, 8'd255, 8'd255);
      send_pixel(10'd6,    13'd4800, 8'd255, 8'd255);
      send_pixel(10'd7,    13'd5759, 8'd255, 8'd255);
      send_pixel(10'd8,    13'd5760, 8'd255, 8'd255);
      send_pixel(10'd9,    13'd8191, 8'd200, 8'd180);
      send_pixel(10'd10,   13'd480,  8'd255, 8'd255);
      send_pixel(10'd11,   13'd1440, 8'd128, 8'd200);
      send_pixel(10'd12,   13'd2400, 8'd0,   8'd255);
      send_pixel(10'd13,   13'd3360, 8'd255, 8'd0);
      send_pixel(10'd14,   13'd4320, 8'd1,   8'd254);
      send_pixel(10'd15,   13'd5280, 8'd254, 8'd1);
      send_pixel(10'd16,   13'd8191, 8'd0,   8'd0);
      send_pixel(10'd1023, 13'd6000, 8'd255, 8'd255);
      send_pixel(10'd512,  13'd1,    8'd255, 8'd255);
      send_pixel(10'd341,  13'd4799, 8'd77,  8'd133);

      // Random: light sender idling, then heavy, then back to back
      for (int phase = 0; phase < 3; phase++) begin
         drain_pipeline();
         idle_pct = (phase == 0) ? 20 : (phase == 1) ? 78 : 0;
         for (int n = 0; n < PER_PHASE; n++) send_random_pixel();
      end

      drain_pipeline();
      repeat (TAIL_WAIT) @(posedge clock);

      $display("Sent %0d pixels and checked %0d responses: all six sectors, their edges,",
               pixels_sent, responses);
      $display("hues of 360 degrees and above, s/v extremes, under three sender idle rates.");
      if (mismatches == 0)
         $display("** hsv_to_rgb_pixel: PASSED **");
      else
         $display("** hsv_to_rgb_pixel: FAILED **");
      $finish;
   end

endmodule

>>> filelist.f
design/hsv2rgb_pkg.sv
design/hsv_to_rgb_pixel.sv
dv/hsv_to_rgb_pixel_check.sv
dv/hsv_to_rgb_pixel_test.sv
